>>> hw/rtl/vwrf_pkg.sv
// Shared types and constants of the vertical weighted row filter.
// Field widths, stream packing offsets, request and register codes.
// No dependencies.
package vwrf_pkg;

  localparam int ROW_W     = 12;
  localparam int WIDX_W    = 12;
  localparam int WEIGHT_W  = 16;
  localparam int SAMPLE_W  = 16;
  localparam int ACC_W     = 36;
  localparam int PROD_W    = WEIGHT_W + SAMPLE_W + 1;
  localparam int NUM_LANES = 4;

  localparam int TAPS_W    = 5;
  localparam int NCH_W     = 3;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 160;

  localparam int IN_WIDX_LSB   = 0;
  localparam int IN_WVAL_LSB   = 12;
  localparam int IN_ROW_LSB    = 28;
  localparam int IN_SAMPLE_LSB = 40;

  localparam int OUT_ROW_LSB = 0;
  localparam int OUT_SUM_LSB = 12;
  localparam int OUT_USED_W  = ROW_W + NUM_LANES * ACC_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_TAPS         = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 1'd1;

  localparam logic REQ_WEIGHT = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0] acc_t;

endpackage

>>> hw/rtl/vwrf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the weight table. No dependencies.
module vwrf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/vertical_weighted_row_filter_core.sv
// A row's result is shown from the accumulate/output register, behind the RAM read and product stages.
// Throughput: one item per cycle; the weight RAM read, the product register and the
// accumulate/output register form a three-stage pipeline that stalls only when a finished
// row meets an output register that is still held.
// Reset (rst, synchronous): clears accumulators, tap counter, pipeline valids and config
// (taps 1, num_channels 1); the weight table is not cleared. Needs vwrf_pkg and vwrf_ram.
module vertical_weighted_row_filter_core #(
  parameter int MAX_TAPS     = 16,
  parameter int WEIGHT_DEPTH = 4096,
  parameter int SAMPLE_BITS  = 16,
  parameter int CHANNELS     = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // weight_index, weight_value, out_row, sample0, sample1, sample2, sample3
  input  logic [vwrf_pkg::IN_DATA_W-1:0]    s_tdata,
  // req_type
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // row_out, sum0, sum1, sum2, sum3, zero fill
  output logic [vwrf_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vwrf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vwrf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW    = $clog2(WEIGHT_DEPTH);
  localparam int TC_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W = ($clog2(MAX_TAPS + 1) > vwrf_pkg::TAPS_W) ?
                         $clog2(MAX_TAPS + 1) : vwrf_pkg::TAPS_W;
  localparam int RAW_W = CNT_W + vwrf_pkg::ROW_W + 1;
  localparam logic [vwrf_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
    vwrf_pkg::SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);

  logic [vwrf_pkg::TAPS_W-1:0] taps;
  logic [vwrf_pkg::NCH_W-1:0]  num_channels;

  logic [CNT_W-1:0] taps_ext;
  logic [CNT_W-1:0] eff_taps;
  logic [vwrf_pkg::NCH_W-1:0] eff_channels;

  logic [TC_W-1:0]  tap_count;
  logic [CNT_W-1:0] tap_inc;
  logic             in_last;
  logic [RAW_W-1:0] raw_addr;

  logic in_accept;
  logic in_sample;
  logic [vwrf_pkg::ROW_W-1:0] in_row;
  vwrf_pkg::sample_t in_smp [vwrf_pkg::NUM_LANES];

  logic [vwrf_pkg::WEIGHT_W-1:0] w_rdata;
  logic                          w_valid;
  logic                          w_last;
  logic [vwrf_pkg::ROW_W-1:0]    w_row;
  vwrf_pkg::sample_t             w_smp [vwrf_pkg::NUM_LANES];
  logic                          w_adv;

  logic                          p_valid;
  logic                          p_last;
  logic [vwrf_pkg::ROW_W-1:0]    p_row;
  vwrf_pkg::prod_t               p_prod [vwrf_pkg::NUM_LANES];
  logic                          p_adv;

  vwrf_pkg::acc_t                acc [vwrf_pkg::NUM_LANES];
  vwrf_pkg::acc_t                out_sum [vwrf_pkg::NUM_LANES];
  logic [vwrf_pkg::ROW_W-1:0]    out_row;
  logic                          out_valid;
  logic                          out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      taps         <= vwrf_pkg::TAPS_W'(1);
      num_channels <= vwrf_pkg::NCH_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        vwrf_pkg::CFG_TAPS:         taps <= cfg_data;
        vwrf_pkg::CFG_NUM_CHANNELS: num_channels <= cfg_data[vwrf_pkg::NCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    taps_ext = CNT_W'(taps);
    if (taps == '0) begin
      eff_taps = CNT_W'(1);
    end else if (taps_ext > CNT_W'(MAX_TAPS)) begin
      eff_taps = CNT_W'(MAX_TAPS);
    end else begin
      eff_taps = taps_ext;
    end
    if (num_channels == '0) begin
      eff_channels = vwrf_pkg::NCH_W'(1);
    end else if (num_channels > vwrf_pkg::NCH_W'(CHANNELS)) begin
      eff_channels = vwrf_pkg::NCH_W'(CHANNELS);
    end else begin
      eff_channels = num_channels;
    end
  end

  assign out_free = !out_valid || m_tready;
  assign p_adv    = !p_valid || !p_last || out_free;
  assign w_adv    = !w_valid || p_adv;
  assign s_tready = w_adv;

  assign in_accept = s_tvalid && s_tready;
  assign in_sample = (s_tuser == vwrf_pkg::REQ_SAMPLE);
  assign in_row    = s_tdata[vwrf_pkg::IN_ROW_LSB +: vwrf_pkg::ROW_W];

  always_comb begin
    for (int c = 0; c < vwrf_pkg::NUM_LANES; c++) begin
      in_smp[c] = s_tdata[vwrf_pkg::IN_SAMPLE_LSB + c * vwrf_pkg::SAMPLE_W +:
                          vwrf_pkg::SAMPLE_W] & SAMPLE_MASK;
    end
  end

  assign tap_inc  = CNT_W'(tap_count) + CNT_W'(1);
  assign in_last  = (tap_inc >= eff_taps);
  assign raw_addr = RAW_W'(eff_taps * in_row) + RAW_W'(tap_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= '0;
    end else if (in_accept && in_sample) begin
      tap_count <= in_last ? '0 : tap_inc[TC_W-1:0];
    end
  end

  vwrf_ram #(
    .WIDTH (vwrf_pkg::WEIGHT_W),
    .DEPTH (WEIGHT_DEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (in_accept && !in_sample),
    .waddr (AW'(s_tdata[vwrf_pkg::IN_WIDX_LSB +: vwrf_pkg::WIDX_W])),
    .wdata (s_tdata[vwrf_pkg::IN_WVAL_LSB +: vwrf_pkg::WEIGHT_W]),
    .re    (in_accept && in_sample),
    .raddr (raw_addr[AW-1:0]),
    .rdata (w_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else if (w_adv) begin
      w_valid <= in_accept && in_sample;
    end
    if (w_adv && in_accept && in_sample) begin
      w_last <= in_last;
      w_row  <= in_row;
      w_smp  <= in_smp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_adv) begin
      p_valid <= w_valid;
    end
    if (p_adv && w_valid) begin
      p_last <= w_last;
      p_row  <= w_row;
      for (int c = 0; c < vwrf_pkg::NUM_LANES; c++) begin
        if (vwrf_pkg::NCH_W'(c) < eff_channels) begin
          p_prod[c] <= $signed(w_rdata) * $signed({1'b0, w_smp[c]});
        end else begin
          p_prod[c] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int c = 0; c < vwrf_pkg::NUM_LANES; c++) begin
        acc[c] <= '0;
      end
    end else begin
      if (p_valid && p_adv) begin
        for (int c = 0; c < vwrf_pkg::NUM_LANES; c++) begin
          acc[c] <= p_last ? '0 : acc[c] + vwrf_pkg::ACC_W'(p_prod[c]);
        end
      end
      if (p_valid && p_adv && p_last) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (p_valid && p_adv && p_last) begin
      out_row <= p_row;
      for (int c = 0; c < vwrf_pkg::NUM_LANES; c++) begin
        if (vwrf_pkg::NCH_W'(c) < eff_channels) begin
          out_sum[c] <= acc[c] + vwrf_pkg::ACC_W'(p_prod[c]);
        end else begin
          out_sum[c] <= '0;
        end
      end
    end
  end

  assign m_tvalid = out_valid;

  always_comb begin
    m_tdata = '0;
    m_tdata[vwrf_pkg::OUT_ROW_LSB +: vwrf_pkg::ROW_W] = out_row;
    for (int c = 0; c < vwrf_pkg::NUM_LANES; c++) begin
      m_tdata[vwrf_pkg::OUT_SUM_LSB + c * vwrf_pkg::ACC_W +: vwrf_pkg::ACC_W] = out_sum[c];
    end
  end

endmodule

>>> hw/rtl/vwrf_checker.sv
// Port-level checks for vertical_weighted_row_filter_core, attached by bind.
// Depends on vwrf_pkg.
module vwrf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [vwrf_pkg::OUT_DATA_W-1:0]   m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result item changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a held result");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result item shown right after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[vwrf_pkg::OUT_DATA_W-1:vwrf_pkg::OUT_USED_W] == '0)
    else $error("result fill bits not zero");

endmodule

bind vertical_weighted_row_filter_core vwrf_checker u_vwrf_checker (.*);
